[sv/mfd_pkg.sv]
package mfd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int MAX_DELAY = 32768;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int Q_SHIFT   = 15;
  localparam int UNITY_Q15 = 32768;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  // Register word index (byte address / 4)
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_MODE     = 3'd1;
  localparam logic [2:0] REG_DELAY    = 3'd2;
  localparam logic [2:0] REG_FEEDBACK = 3'd3;
  localparam logic [2:0] REG_PRESCALE = 3'd4;

  typedef enum logic [1:0] {
    MODE_ECHO   = 2'd0,
    MODE_DELAY  = 2'd1,
    MODE_REVERB = 2'd2,
    MODE_LATE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB
  } state_t;

  typedef struct packed {
    logic                enable;
    mode_t               mode;
    logic [LEN_W-1:0]    delay_samples;
    logic [GAIN_W-1:0]   feedback_gain;
    logic [GAIN_W-1:0]   input_prescale;
  } cfg_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [17:0] v);
    logic signed [17:0] hi;
    logic signed [17:0] lo;
    hi = 18'sd32767;
    lo = -18'sd32768;
    if (v > hi) begin
      return SAMPLE_W'(hi);
    end else if (v < lo) begin
      return SAMPLE_W'(lo);
    end
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
    return (v > GAIN_W'(UNITY_Q15)) ? GAIN_W'(UNITY_Q15) : v;
  endfunction

endpackage

[sv/mfd_regs.sv]
module mfd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfd_pkg::PADDR_W-1:0] paddr,
  input  logic [mfd_pkg::PDATA_W-1:0] pwdata,
  output logic [mfd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output mfd_pkg::cfg_t               cfg,
  output logic                        line_clear
);
  import mfd_pkg::*;

  logic             wr_en;
  logic [2:0]       idx;
  logic [LEN_W-1:0] len_wr;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  assign line_clear = wr_en && (idx == REG_DELAY);

  // zero acts as one, above the ring size saturates
  always_comb begin
    len_wr = LEN_W'(pwdata[15:0]);
    if (pwdata[15:0] == 16'd0) begin
      len_wr = LEN_W'(1);
    end else if (pwdata[15:0] > 16'(MAX_DELAY)) begin
      len_wr = LEN_W'(MAX_DELAY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.mode           <= MODE_ECHO;
      cfg.delay_samples  <= LEN_W'(1);
      cfg.feedback_gain  <= '0;
      cfg.input_prescale <= GAIN_W'(UNITY_Q15);
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLE:   cfg.enable         <= pwdata[0];
        REG_MODE:     cfg.mode           <= mode_t'(pwdata[1:0]);
        REG_DELAY:    cfg.delay_samples  <= len_wr;
        REG_FEEDBACK: cfg.feedback_gain  <= clamp_gain(pwdata[GAIN_W-1:0]);
        REG_PRESCALE: cfg.input_prescale <= clamp_gain(pwdata[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:   prdata = PDATA_W'(cfg.enable);
      REG_MODE:     prdata = PDATA_W'(cfg.mode);
      REG_DELAY:    prdata = PDATA_W'(cfg.delay_samples);
      REG_FEEDBACK: prdata = PDATA_W'(cfg.feedback_gain);
      REG_PRESCALE: prdata = PDATA_W'(cfg.input_prescale);
      default:      prdata = '0;
    endcase
  end

endmodule

[sv/multimode_feedback_delay.sv]
// Multimode feedback delay: one signed 16-bit interleaved sample per transfer in, one
// result (processed sample plus the tap read from the line) per transfer out. The line
// is a single-port-write, registered-read memory of 32768 x 16 bits holding the last
// delay_samples stored values. From input transfer to the result being offered, a
// sample passes the ring read at the transfer edge, one multiply stage, then
// add/saturate and write-back.
// A new sample waits for the previous write-back, as set by the ring read-modify-write
// loop, the next sample's read overlapping the current write-back, with a bypass when
// both hit the same entry. A stalled output holds the write-back and hence the input.
// There is no clearing pass: a fill flag records whether the write pointer has wrapped
// since reset or the last write of delay_samples, and taps from the unfilled part read
// as zero, so writing delay_samples clears the line at once. The user must configure
// through the APB port only while no sample is in flight; the block does not enforce it.
module multimode_feedback_delay (
  input  logic                          clk,
  input  logic                          rst,
  // APB
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfd_pkg::PADDR_W-1:0]   paddr,
  input  logic [mfd_pkg::PDATA_W-1:0]   pwdata,
  output logic [mfd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // sample in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [mfd_pkg::SAMPLE_W-1:0] sample_in,
  // result out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [mfd_pkg::SAMPLE_W-1:0] sample_out,
  output logic signed [mfd_pkg::SAMPLE_W-1:0] tap_out
);
  import mfd_pkg::*;

  cfg_t cfg;
  logic line_clear;

  mfd_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .line_clear (line_clear)
  );

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_t state, state_next;
  logic   accept;
  logic   wb_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wb_go      = 1'b0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_WB;
      end
      ST_WB: begin
        // write-back only when the output register is free or draining
        if (!out_valid || !out_stall) begin
          wb_go      = 1'b1;
          in_stall   = 1'b0;
          state_next = in_valid ? ST_MUL : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Ring pointer and fill flag
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] pos;
  logic              wrapped;
  logic [LEN_W-1:0]  pos_inc;
  logic              pos_wrap;
  logic [ADDR_W-1:0] pos_adv;
  logic              ring_we;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_filled;

  assign pos_inc  = {1'b0, pos} + LEN_W'(1);
  assign pos_wrap = (pos_inc >= cfg.delay_samples);
  assign pos_adv  = pos_wrap ? '0 : pos_inc[ADDR_W-1:0];
  assign ring_we  = wb_go && cfg.enable;

  // the next sample reads where this write-back leaves the pointer
  assign rd_addr   = ring_we ? pos_adv : pos;
  assign rd_filled = ring_we ? (wrapped || pos_wrap) : wrapped;

  always_ff @(posedge clk) begin
    if (rst || line_clear) begin
      pos     <= '0;
      wrapped <= 1'b0;
    end else if (ring_we) begin
      pos     <= pos_adv;
      wrapped <= wrapped || pos_wrap;
    end
  end

  // ---------------------------------------------------------------------------
  // Delay line memory
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] ring [MAX_DELAY];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] store;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[pos] <= store;
    end
    if (accept) begin
      rd_data <= ring[rd_addr];
    end
  end

  // bypass: read and write-back on the same entry in one cycle (length one)
  logic                       fwd;
  logic signed [SAMPLE_W-1:0] fwd_data;
  logic                       tap_filled;
  logic signed [SAMPLE_W-1:0] s_reg;

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd        <= ring_we && (pos_adv == pos);
      fwd_data   <= store;
      tap_filled <= rd_filled;
      s_reg      <= sample_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] tap;
  logic        [30:0]         pg;          // prescale * feedback, up to 2^30
  logic signed [GAIN_W:0]     p_s;
  logic signed [GAIN_W:0]     g_s;
  logic signed [31:0]         pg_s;
  logic signed [31:0]         sp;          // in * prescale
  logic signed [31:0]         tg;          // tap * feedback
  logic signed [31:0]         sg;          // in * feedback
  logic signed [46:0]         spg;         // in * prescale * feedback
  logic signed [SAMPLE_W-1:0] tap_reg;

  assign tap  = fwd ? fwd_data : (tap_filled ? rd_data : '0);
  assign p_s  = $signed({1'b0, cfg.input_prescale});
  assign g_s  = $signed({1'b0, cfg.feedback_gain});
  assign pg_s = $signed({1'b0, pg});

  // gains are static while samples flow, so this product is always settled
  always_ff @(posedge clk) begin
    pg <= 31'(32'(cfg.input_prescale) * 32'(cfg.feedback_gain));
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      sp      <= 32'(s_reg) * 32'(p_s);
      tg      <= 32'(tap) * 32'(g_s);
      sg      <= 32'(s_reg) * 32'(g_s);
      spg     <= 47'(s_reg) * 47'(pg_s);
      tap_reg <= tap;
    end
  end

  // ---------------------------------------------------------------------------
  // Write-back stage: truncate toward zero, sum, saturate
  // ---------------------------------------------------------------------------
  logic signed [31:0]         sp_adj;
  logic signed [16:0]         x;
  logic signed [32:0]         ed_sum;
  logic signed [32:0]         ed_adj;
  logic signed [17:0]         ed_q;
  logic signed [47:0]         rv_sum;
  logic signed [47:0]         rv_adj;
  logic signed [17:0]         rv_q;
  logic signed [31:0]         sg_adj;
  logic signed [16:0]         lt_q;
  logic signed [SAMPLE_W-1:0] y;

  assign sp_adj = sp + (sp[31] ? 32'sd32767 : 32'sd0);
  assign x      = 17'(sp_adj >>> Q_SHIFT);

  // echo / delay: (x*2^15 + tap*g) / 2^15
  assign ed_sum = (33'(x) <<< Q_SHIFT) + 33'(tg);
  assign ed_adj = ed_sum + (ed_sum[32] ? 33'sd32767 : 33'sd0);
  assign ed_q   = 18'(ed_adj >>> Q_SHIFT);

  // reverb: (in*p*g + tap*g*2^15) / 2^30
  assign rv_sum = 48'(spg) + (48'(tg) <<< Q_SHIFT);
  assign rv_adj = rv_sum + (rv_sum[47] ? 48'sd1073741823 : 48'sd0);
  assign rv_q   = 18'(rv_adj >>> (2 * Q_SHIFT));

  // late: in*g / 2^15
  assign sg_adj = sg + (sg[31] ? 32'sd32767 : 32'sd0);
  assign lt_q   = 17'(sg_adj >>> Q_SHIFT);

  always_comb begin
    y     = s_reg;
    store = '0;
    case (cfg.mode)
      MODE_ECHO: begin
        y     = sat_sample(ed_q);
        store = sat_sample(ed_q);
      end
      MODE_DELAY: begin
        y     = sat_sample(ed_q);
        store = sat_sample(18'(x));
      end
      MODE_REVERB: begin
        store = sat_sample(rv_q);
      end
      MODE_LATE: begin
        store = sat_sample(18'(lt_q));
      end
      default: begin
        store = '0;
      end
    endcase
    if (!cfg.enable) begin
      y = s_reg;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      sample_out <= y;
      tap_out    <= tap_reg;
    end
  end

endmodule

[sim/delay_checker.sv]
module delay_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mfd_pkg::PADDR_W-1:0]         paddr,
  input  logic [mfd_pkg::PDATA_W-1:0]         pwdata,
  input  logic                                pready,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [mfd_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [mfd_pkg::SAMPLE_W-1:0] sample_out,
  input  logic signed [mfd_pkg::SAMPLE_W-1:0] tap_out,
  output int                                  failures,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mfd_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] tap;
  } line_result_t;

  // shadow of the line and the registers
  logic signed [SAMPLE_W-1:0] line_mem [MAX_DELAY];
  int unsigned                line_pos;
  int unsigned                line_len;
  logic                       en;
  mode_t                      md;
  int unsigned                fb_gain;
  int unsigned                pre_gain;

  line_result_t               expected_q [$];

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    failures++;
  endtask

  function automatic longint sat16(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic int unsigned limit_gain(input logic [PDATA_W-1:0] v);
    int unsigned g;
    g = v[15:0];
    return (g > UNITY_Q15) ? UNITY_Q15 : g;
  endfunction

  task automatic clear_line();
    for (int i = 0; i < MAX_DELAY; i++) begin
      line_mem[i] = '0;
    end
    line_pos = 0;
  endtask

  task automatic apply_write(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
    int unsigned d;
    case (idx)
      REG_ENABLE: begin
        en = val[0];
      end
      REG_MODE: begin
        md = mode_t'(val[1:0]);
      end
      REG_DELAY: begin
        d = val[15:0];
        if (d < 1) d = 1;
        if (d > MAX_DELAY) d = MAX_DELAY;
        line_len = d;
        clear_line();
      end
      REG_FEEDBACK: begin
        fb_gain = limit_gain(val);
      end
      REG_PRESCALE: begin
        pre_gain = limit_gain(val);
      end
      default: begin
      end
    endcase
  endtask

  // one sample through the line: returns the result and advances the shadow state
  function automatic line_result_t process_sample(input logic signed [SAMPLE_W-1:0] din);
    line_result_t r;
    longint s, g, p, x, tap, y, keep, unity;
    unity = UNITY_Q15;
    s     = din;
    g     = fb_gain;
    p     = pre_gain;
    if (line_pos >= line_len) line_pos = 0;
    tap   = line_mem[line_pos];
    y     = s;
    if (en) begin
      x = (s * p) / unity;
      case (md)
        MODE_ECHO: begin
          y    = sat16((x * unity + tap * g) / unity);
          keep = y;
        end
        MODE_DELAY: begin
          keep = sat16(x);
          y    = sat16((x * unity + tap * g) / unity);
        end
        MODE_REVERB: begin
          keep = sat16(((s * p + tap * unity) * g) / (unity * unity));
        end
        default: begin
          keep = sat16((s * g) / unity);
        end
      endcase
      line_mem[line_pos] = SAMPLE_W'(keep);
      line_pos = (line_pos + 1 >= line_len) ? 0 : line_pos + 1;
    end
    r.sample = SAMPLE_W'(y);
    r.tap    = SAMPLE_W'(tap);
    return r;
  endfunction

  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      clear_line();
      line_len = 1;
      en       = 1'b0;
      md       = MODE_ECHO;
      fb_gain  = 0;
      pre_gain = UNITY_Q15;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          flag_error($sformatf("result %0d/%0d with nothing outstanding", sample_out, tap_out));
        end else begin
          want = expected_q.pop_front();
          if (sample_out !== want.sample)
            flag_error($sformatf("sample_out %0d, want %0d", sample_out, want.sample));
          if (tap_out !== want.tap)
            flag_error($sformatf("tap_out %0d, want %0d", tap_out, want.tap));
        end
      end
      if (psel && penable && pwrite && pready)
        apply_write(paddr[4:2], pwdata);
      if (in_valid && !in_stall)
        expected_q.push_back(process_sample(sample_in));
    end
    pending = expected_q.size();
  end

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mfd_pkg::*;

  // generous ceiling for ~750 samples at worst-case idling
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 700;

  // word indexes with no register behind them; writes there must be ignored
  localparam logic [2:0] REG_SPARE_A = 3'd5;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [PADDR_W-1:0]          paddr = '0;
  logic [PDATA_W-1:0]          pwdata = '0;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  sample_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_out;
  logic signed [SAMPLE_W-1:0]  tap_out;

  int                          failures;
  int                          pending;
  int                          cycle_count = 0;

  // idling odds, percent of cycles
  int unsigned                 send_gap_pct = 0;
  int unsigned                 recv_stall_pct = 0;

  multimode_feedback_delay DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .tap_out    (tap_out)
  );

  // Predicts every result from the transfers it sees and compares; we only read back
  // its failure count and the number of results still outstanding.
  delay_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .tap_out    (tap_out),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver back-pressure, redrawn every cycle on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Idling profile per phase: none, sender mostly idle, receiver mostly
  // stalling, then light idling on both sides.
  task automatic set_idling(input int kind);
    case (kind % 4)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 86; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 86; end
      default: begin send_gap_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  // One sample transfer. Called and returning on a falling edge, so in_valid is
  // only ever assigned once per time step; a following sample keeps it high.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending, let every outstanding result drain, then a few spare cycles
  // to cover the pipeline before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // APB write: setup then access phase, then idle with psel low so psel is never
  // dropped and raised in the same step by back-to-back writes.
  task automatic reg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Fill the bits above a register's width with junk when asked; they must be
  // ignored by the decode.
  function automatic logic [PDATA_W-1:0] word_of(input logic [PDATA_W-1:0] v,
                                                  input int unsigned keep_bits,
                                                  input bit dirty);
    logic [PDATA_W-1:0] mask;
    mask = (32'h1 << keep_bits) - 32'h1;
    return dirty ? (($urandom() & ~mask) | (v & mask)) : (v & mask);
  endfunction

  task automatic configure(input logic en, input mode_t md, input logic [15:0] dly,
                           input logic [15:0] fb, input logic [15:0] pre,
                           input bit set_len, input bit dirty);
    settle();
    reg_write(REG_ENABLE, word_of(32'(en), 1, dirty));
    reg_write(REG_MODE, word_of(32'(md), 2, dirty));
    if (set_len) reg_write(REG_DELAY, word_of(32'(dly), 16, dirty));
    reg_write(REG_FEEDBACK, word_of(32'(fb), 16, dirty));
    reg_write(REG_PRESCALE, word_of(32'(pre), 16, dirty));
  endtask

  function automatic logic [15:0] pick_gain();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 16'd0;
      1: return 16'(UNITY_Q15);
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(UNITY_Q15));
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(19);
    case (r)
      0: return 16'd0;
      1: return 16'(MAX_DELAY);
      2: return 16'($urandom_range(32769, 65535));
      3: return 16'd1;
      4, 5: return 16'($urandom_range(25, 2000));
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(64)) - 16'sd32;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int          phase;
    int          n;
    int          rand_items;
    logic        en;
    mode_t       md;
    bit          set_len;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed part ----
    // straight after reset: disabled, line of one, samples pass unchanged
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);

    // echo at full gain; zero length behaves as one, gains above unity clamp
    configure(1'b1, MODE_ECHO, 16'd0, 16'hFFFF, 16'd40000, 1'b1, 1'b0);
    reg_write(REG_SPARE_A, 32'hFFFF_FFFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh8000);
    push_sample(-16'sd1);

    // single delay, half prescale, short line so taps come round
    configure(1'b1, MODE_DELAY, 16'd3, 16'(UNITY_Q15), 16'd16384, 1'b1, 1'b0);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sd1);
    push_sample(-16'sd1);
    push_sample(16'sd0);
    push_sample(16'sd12345);

    // reverb with a length written above the maximum
    configure(1'b1, MODE_REVERB, 16'hFFFF, 16'(UNITY_Q15), 16'(UNITY_Q15), 1'b1, 1'b0);
    reg_write(REG_SPARE_B, 32'h0000_0001);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sd100);

    // late-only, zero gains then full feedback
    configure(1'b1, MODE_LATE, 16'd2, 16'd0, 16'd0, 1'b1, 1'b0);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sd5);
    configure(1'b1, MODE_LATE, 16'd2, 16'(UNITY_Q15), 16'd0, 1'b1, 1'b0);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sd7);
    push_sample(-16'sd7);

    // disabled over a filled line: taps show, the line must not move
    settle();
    reg_write(REG_ENABLE, 32'h0);
    push_sample(16'sd1);
    push_sample(16'sd2);

    // ---- random part ----
    // Each phase picks a fresh setting and idling profile; the length is kept
    // now and then so the line carries over a change of mode or gains.
    phase      = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      en      = ($urandom_range(7) != 0);
      md      = mode_t'($urandom_range(3));
      set_len = (phase == 0) || ($urandom_range(2) != 0);
      configure(en, md, pick_length(), pick_gain(), pick_gain(), set_len,
                ($urandom_range(3) == 0));
      if ($urandom_range(9) == 0) reg_write(REG_SPARE_A, $urandom());
      set_idling(phase);
      n = $urandom_range(20, 60);
      for (int i = 0; i < n; i++) begin
        // every fifth phase the sender holds off mid-stream until all is drained
        if (phase % 5 == 2 && i == n / 2) begin
          settle();
        end
        push_sample(pick_sample());
      end
      rand_items += n;
      phase++;
    end

    // ---- wind-down ----
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mfd_pkg.sv
sv/mfd_regs.sv
sv/multimode_feedback_delay.sv
sim/delay_checker.sv
sim/testbench.sv
